>>> rtl/ked_pkg.sv
// Package for the keypad digit entry editor.
// Holds key codes, status codes, register addresses, the ALU request type and
// the power-of-ten table. No dependencies.
`default_nettype none

package ked_pkg;

	localparam int unsigned MAX_DIGITS = 9;
	localparam int unsigned VAL_W      = 30;
	localparam int unsigned CUR_W      = 4;
	localparam int unsigned ALU_W      = VAL_W + 1;

	localparam logic [7:0] KEY_0    = 8'h30;
	localparam logic [7:0] KEY_9    = 8'h39;
	localparam logic [7:0] KEY_STAR = 8'h2A;
	localparam logic [7:0] KEY_HASH = 8'h23;

	localparam logic [2:0] ST_NONE         = 3'd0;
	localparam logic [2:0] ST_CANCEL       = 3'd1;
	localparam logic [2:0] ST_CONFIRM      = 3'd2;
	localparam logic [2:0] ST_HINT_CONFIRM = 3'd3;
	localparam logic [2:0] ST_HINT_CANCEL  = 3'd4;

	localparam logic [2:0] ADDR_DIGIT_COUNT = 3'd0;
	localparam logic [2:0] ADDR_START_VALUE = 3'd4;
	localparam int unsigned REG_SEL_BIT     = 2;

	localparam logic [CUR_W-1:0] DIGIT_COUNT_RESET = 4'd4;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] res;
		logic             ge;   // a >= b, meaningful on subtract
	} alu_rsp_t;

	function automatic logic [VAL_W-1:0] pow10(input logic [CUR_W-1:0] p);
		logic [VAL_W-1:0] r;
		case (p)
			4'd0:    r = 30'd1;
			4'd1:    r = 30'd10;
			4'd2:    r = 30'd100;
			4'd3:    r = 30'd1000;
			4'd4:    r = 30'd10000;
			4'd5:    r = 30'd100000;
			4'd6:    r = 30'd1000000;
			4'd7:    r = 30'd10000000;
			4'd8:    r = 30'd100000000;
			4'd9:    r = 30'd1000000000;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ked_alu.sv
// Shared add/subtract and compare unit of the editor.
// Depends on ked_pkg for the request and response types.
`default_nettype none

module ked_alu (
	input  ked_pkg::alu_req_t req,
	output ked_pkg::alu_rsp_t rsp
);

	logic [ked_pkg::ALU_W-1:0] b_op;
	logic [ked_pkg::ALU_W:0]   sum;

	assign b_op = req.sub ? ~req.b : req.b;
	assign sum  = {1'b0, req.a} + {1'b0, b_op} + {{ked_pkg::ALU_W{1'b0}}, req.sub};

	assign rsp.res = sum[ked_pkg::ALU_W-1:0];
	assign rsp.ge  = sum[ked_pkg::ALU_W];

endmodule

`default_nettype wire

>>> rtl/ked_core.sv
// Sequencer, edit state and result register of the editor.
// Depends on ked_pkg and ked_alu (one shared add/subtract unit).
`default_nettype none

module ked_core (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire  [ked_pkg::CUR_W-1:0]        digits,
	input  wire                              load,
	input  wire  [ked_pkg::VAL_W-1:0]        load_value,
	input  wire                              key_valid,
	output logic                             key_ready,
	input  wire  [7:0]                       key_code,
	output logic                             res_valid,
	input  wire                              res_ready,
	output logic [2:0]                       status,
	output logic [ked_pkg::VAL_W-1:0]        edited_value,
	output logic [ked_pkg::CUR_W-1:0]        cursor_index
);

	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_HIGH, S_MODW, S_LOW, S_ADDK, S_DONE
	} state_t;

	state_t                      state_q;
	logic [ked_pkg::VAL_W-1:0]   v_q;
	logic [ked_pkg::CUR_W-1:0]   cur_q;
	logic [ked_pkg::VAL_W-1:0]   rem_q;
	logic [ked_pkg::VAL_W-1:0]   acc_q;
	logic [ked_pkg::VAL_W-1:0]   w_q;
	logic [ked_pkg::VAL_W-1:0]   div_q;
	logic [4:0]                  cnt_q;
	logic [3:0]                  k_q;
	logic [2:0]                  stat_q;

	ked_pkg::alu_req_t           req;
	ked_pkg::alu_rsp_t           rsp;

	logic                        accept;
	logic                        is_digit;
	logic [ked_pkg::CUR_W-1:0]   pos;
	logic [3:0]                  key_off;
	logic [2:0]                  final_status;
	logic                        out_free;

	ked_alu u_alu (
		.req (req),
		.rsp (rsp)
	);

	assign key_ready = (state_q == S_IDLE) && !load;
	assign accept    = key_valid && key_ready;
	assign is_digit  = (key_code >= ked_pkg::KEY_0) && (key_code <= ked_pkg::KEY_9);
	assign pos       = digits - cur_q - 4'd1;
	assign key_off   = 4'(key_code - ked_pkg::KEY_0);
	assign out_free  = !res_valid || res_ready;

	always_comb begin
		if (stat_q != ked_pkg::ST_NONE) begin
			final_status = stat_q;
		end else if (cur_q >= digits) begin
			final_status = ked_pkg::ST_HINT_CONFIRM;
		end else if (cur_q == '0) begin
			final_status = ked_pkg::ST_HINT_CANCEL;
		end else begin
			final_status = ked_pkg::ST_NONE;
		end
	end

	// operand selection for the shared unit
	always_comb begin
		req = '0;
		case (state_q)
			S_DIV: begin
				req.a   = {rem_q, v_q[cnt_q]};
				req.b   = {1'b0, div_q};
				req.sub = 1'b1;
			end
			S_HIGH: begin
				req.a   = {1'b0, v_q};
				req.b   = {1'b0, rem_q};
				req.sub = 1'b1;
			end
			S_MODW: begin
				req.a   = {1'b0, rem_q};
				req.b   = {1'b0, w_q};
				req.sub = 1'b1;
			end
			S_LOW: begin
				req.a   = {1'b0, acc_q};
				req.b   = {1'b0, rem_q};
				req.sub = 1'b0;
			end
			S_ADDK: begin
				req.a   = {1'b0, acc_q};
				req.b   = {1'b0, w_q};
				req.sub = 1'b0;
			end
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			v_q          <= '0;
			cur_q        <= '0;
			stat_q       <= ked_pkg::ST_NONE;
			res_valid    <= 1'b0;
			status       <= ked_pkg::ST_NONE;
			edited_value <= '0;
			cursor_index <= '0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (load) begin
						v_q   <= load_value;
						cur_q <= '0;
					end else if (accept) begin
						if (is_digit) begin
							stat_q <= ked_pkg::ST_NONE;
							if (cur_q < digits) begin
								// value = v - (v mod 10w) + (v mod w) + k*w
								w_q     <= ked_pkg::pow10(pos);
								div_q   <= ked_pkg::pow10(pos + 4'd1);
								rem_q   <= '0;
								cnt_q   <= 5'(ked_pkg::VAL_W - 1);
								k_q     <= key_off;
								cur_q   <= cur_q + 4'd1;
								state_q <= S_DIV;
							end else begin
								state_q <= S_DONE;
							end
						end else begin
							state_q <= S_DONE;
							if (key_code == ked_pkg::KEY_STAR) begin
								if (cur_q == '0) begin
									stat_q <= ked_pkg::ST_CANCEL;
								end else begin
									stat_q <= ked_pkg::ST_NONE;
									cur_q  <= cur_q - 4'd1;
								end
							end else if (key_code == ked_pkg::KEY_HASH) begin
								if (cur_q >= digits) begin
									stat_q <= ked_pkg::ST_CONFIRM;
								end else begin
									stat_q <= ked_pkg::ST_NONE;
									cur_q  <= cur_q + 4'd1;
								end
							end else begin
								stat_q <= ked_pkg::ST_NONE;
							end
						end
					end
				end
				S_DIV: begin
					// restoring remainder step, one bit of v per cycle
					if (rsp.ge) begin
						rem_q <= rsp.res[ked_pkg::VAL_W-1:0];
					end else begin
						rem_q <= req.a[ked_pkg::VAL_W-1:0];
					end
					if (cnt_q == '0) begin
						state_q <= S_HIGH;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				S_HIGH: begin
					acc_q   <= rsp.res[ked_pkg::VAL_W-1:0];
					state_q <= S_MODW;
				end
				S_MODW: begin
					if (rsp.ge) begin
						rem_q <= rsp.res[ked_pkg::VAL_W-1:0];
					end else begin
						state_q <= S_LOW;
					end
				end
				S_LOW: begin
					acc_q   <= rsp.res[ked_pkg::VAL_W-1:0];
					state_q <= S_ADDK;
				end
				S_ADDK: begin
					if (k_q == '0) begin
						v_q     <= acc_q;
						state_q <= S_DONE;
					end else begin
						acc_q <= rsp.res[ked_pkg::VAL_W-1:0];
						k_q   <= k_q - 4'd1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						status       <= final_status;
						edited_value <= v_q;
						cursor_index <= cur_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/keypad_digit_entry_editor.sv
// Top level of the keypad digit entry editor: register port, clamping of the
// configuration and the editing core. Depends on ked_pkg and ked_core.
//
// channel   direction  handshake                 payload
// key       in         key_valid / key_ready     key_code
// result    out        res_valid / res_ready     status, edited_value, cursor_index
// config    in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// A digit key runs the bit-serial remainder by 10^(p+1), then subtract steps for the
// remainder by 10^p and add steps of 10^p, all through the one shared adder. Other keys,
// and digit keys past the last digit, go straight to the result state.
// key_ready is low while a key is being worked and while its result waits for a
// free output register. Reset clears the cursor, loads value 0 and digit count 4.
`default_nettype none

module keypad_digit_entry_editor #(
	parameter int unsigned MAX_DIGITS = ked_pkg::MAX_DIGITS
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [2:0]                  paddr,
	input  wire  [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  wire                         key_valid,
	output logic                        key_ready,
	input  wire  [7:0]                  key_code,
	output logic                        res_valid,
	input  wire                         res_ready,
	output logic [2:0]                  status,
	output logic [ked_pkg::VAL_W-1:0]   edited_value,
	output logic [ked_pkg::CUR_W-1:0]   cursor_index
);

	localparam logic [ked_pkg::VAL_W-1:0] VALUE_TOP =
		ked_pkg::pow10(ked_pkg::CUR_W'(MAX_DIGITS)) - 30'd1;
	localparam logic [ked_pkg::CUR_W-1:0] DIGITS_TOP = ked_pkg::CUR_W'(MAX_DIGITS);

	logic [ked_pkg::CUR_W-1:0] dc_q;
	logic [ked_pkg::VAL_W-1:0] sv_q;
	logic                      wr;
	logic                      wr_sv;
	logic [ked_pkg::VAL_W-1:0] sv_in;
	logic [ked_pkg::VAL_W-1:0] sv_clamped;
	logic [ked_pkg::CUR_W-1:0] digits;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign wr_sv  = wr && paddr[ked_pkg::REG_SEL_BIT];

	assign sv_in      = pwdata[ked_pkg::VAL_W-1:0];
	assign sv_clamped = (sv_in > VALUE_TOP) ? VALUE_TOP : sv_in;

	always_comb begin
		if (dc_q == '0) begin
			digits = 4'd1;
		end else if (dc_q > DIGITS_TOP) begin
			digits = DIGITS_TOP;
		end else begin
			digits = dc_q;
		end
	end

	always_comb begin
		case (paddr)
			ked_pkg::ADDR_DIGIT_COUNT: prdata = {28'd0, dc_q};
			ked_pkg::ADDR_START_VALUE: prdata = {2'd0, sv_q};
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q <= ked_pkg::DIGIT_COUNT_RESET;
			sv_q <= '0;
		end else if (wr) begin
			if (paddr[ked_pkg::REG_SEL_BIT]) begin
				sv_q <= sv_in;
			end else begin
				dc_q <= pwdata[ked_pkg::CUR_W-1:0];
			end
		end
	end

	ked_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.digits       (digits),
		.load         (wr_sv),
		.load_value   (sv_clamped),
		.key_valid    (key_valid),
		.key_ready    (key_ready),
		.key_code     (key_code),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.status       (status),
		.edited_value (edited_value),
		.cursor_index (cursor_index)
	);

endmodule

`default_nettype wire
